FILE: sv/reversible_deque_engine_macros.svh
// Assertion macros shared by the deque engine.
`ifndef REVERSIBLE_DEQUE_ENGINE_MACROS_SVH
`define REVERSIBLE_DEQUE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RDE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rde_pkg.sv
package rde_pkg;

    localparam int OP_W   = 2;
    localparam int VAL_W  = 31;
    localparam int KIND_W = 2;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_REV  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd2;
    localparam logic [OP_W-1:0] OP_FIN  = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] K_ELEM  = 2'd0;
    localparam logic [KIND_W-1:0] K_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] K_ERR   = 2'd2;
    localparam logic [KIND_W-1:0] K_OVF   = 2'd3;

    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [KIND_W-1:0] t_kind;

endpackage

FILE: sv/reversible_deque_engine.sv
// Reversible deque engine. Load, reverse and delete requests are taken one
// per cycle while no drain is in progress and produce no result. A finish
// request drains the content in logical order at one element per cycle while
// the output is not stalled, set by the single registered read port of the
// element memory, and holds off new requests until its last element is read;
// an empty, error or overflow finish gives one result and holds off requests
// until it is registered. While the last results of a drain still wait
// downstream, the engine already takes further load, reverse and delete
// requests. Memory contents are never cleared; only live slots are read.
`include "reversible_deque_engine_macros.svh"

module reversible_deque_engine #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rde_pkg::OP_W-1:0]      i_opcode,
    input  logic [rde_pkg::VAL_W-1:0]     i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rde_pkg::KIND_W-1:0]    o_kind,
    output logic [rde_pkg::VAL_W-1:0]     o_value_res,
    output logic                          o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    // Ring pointer helpers, all values stay below DEPTH.
    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] ptr);
        f_inc = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] ptr);
        f_dec = (ptr == '0) ? AW'(DEPTH - 1) : ptr - 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_add(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        f_add = sum[AW-1:0];
    endfunction

    // Deque state.
    logic              r_state;
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic              r_rev;
    logic              r_err;
    logic              r_ovf;

    // Drain context.
    logic [AW-1:0]     r_dr_ptr;
    logic [CW-1:0]     r_dr_left;
    logic              r_dr_rev;
    logic              r_dr_spec;
    rde_pkg::t_kind    r_dr_kind;

    // Read in flight and output register.
    logic              r_rd_pending;
    logic              r_rd_last;
    rde_pkg::t_value   r_rd_data;
    logic              r_out_valid;
    rde_pkg::t_kind    r_out_kind;
    rde_pkg::t_value   r_out_value;
    logic              r_out_last;

    rde_pkg::t_value   mem [DEPTH];

    logic              in_acc;
    logic              out_free;
    logic              rd_en;
    logic              spec_emit;
    logic              pend_move;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     head_dec;
    logic              is_full;

    assign in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pend_move = r_rd_pending && out_free;
    assign rd_en     = (r_state == ST_DRAIN) && !r_dr_spec && (r_dr_left != '0)
                       && (!r_rd_pending || out_free);
    assign spec_emit = (r_state == ST_DRAIN) && r_dr_spec && !r_rd_pending && out_free;

    assign is_full   = (r_count == CW'(DEPTH));
    assign head_dec  = f_dec(r_head);
    assign mem_we    = in_acc && (i_opcode == rde_pkg::OP_LOAD) && !is_full;
    assign mem_waddr = r_rev ? head_dec : f_add(r_head, r_count);

    // Element memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_dr_ptr];
        end
    end

    // Request handling and drain sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_rev     <= 1'b0;
            r_err     <= 1'b0;
            r_ovf     <= 1'b0;
            r_dr_left <= '0;
            r_dr_spec <= 1'b0;
        end else if (r_state == ST_IDLE) begin
            if (in_acc) begin
                case (i_opcode)
                    rde_pkg::OP_LOAD: begin
                        if (is_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            if (r_rev) begin
                                r_head <= head_dec;
                            end
                            r_count <= r_count + 1'b1;
                        end
                    end
                    rde_pkg::OP_REV: begin
                        r_rev <= !r_rev;
                    end
                    rde_pkg::OP_DEL: begin
                        if (!r_err) begin
                            if (r_count == '0) begin
                                r_err <= 1'b1;
                            end else begin
                                if (!r_rev) begin
                                    r_head <= f_inc(r_head);
                                end
                                r_count <= r_count - 1'b1;
                            end
                        end
                    end
                    default: begin
                        // Finish: snapshot the content, then clear the deque.
                        r_state   <= ST_DRAIN;
                        r_dr_rev  <= r_rev;
                        r_dr_ptr  <= r_rev ? f_add(r_head, r_count - 1'b1) : r_head;
                        r_dr_spec <= r_ovf || r_err || (r_count == '0);
                        r_dr_left <= (r_ovf || r_err) ? '0 : r_count;
                        if (r_ovf) begin
                            r_dr_kind <= rde_pkg::K_OVF;
                        end else if (r_err) begin
                            r_dr_kind <= rde_pkg::K_ERR;
                        end else begin
                            r_dr_kind <= rde_pkg::K_EMPTY;
                        end
                        r_head  <= '0;
                        r_count <= '0;
                        r_rev   <= 1'b0;
                        r_err   <= 1'b0;
                        r_ovf   <= 1'b0;
                    end
                endcase
            end
        end else begin
            if (spec_emit) begin
                r_state <= ST_IDLE;
            end
            if (rd_en) begin
                r_dr_left <= r_dr_left - 1'b1;
                r_dr_ptr  <= r_dr_rev ? f_dec(r_dr_ptr) : f_inc(r_dr_ptr);
                if (r_dr_left == CW'(1)) begin
                    r_state <= ST_IDLE;
                end
            end
        end
    end

    // Read stage: tracks the element fetched from memory until it moves to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pending <= 1'b0;
        end else if (rd_en) begin
            r_rd_pending <= 1'b1;
        end else if (pend_move) begin
            r_rd_pending <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_last <= (r_dr_left == CW'(1));
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= pend_move || spec_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out_kind  <= rde_pkg::K_ELEM;
            r_out_value <= r_rd_data;
            r_out_last  <= r_rd_last;
        end else if (spec_emit) begin
            r_out_kind  <= r_dr_kind;
            r_out_value <= '0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_value_res = r_out_value;
    assign o_last      = r_out_last;

    // Checks on the drain path and the state clear.
    `RDE_ASSERT_NEXT(a_read_lands, i_clk, i_rst_n, rd_en, r_rd_pending,
        "memory read did not land in the read stage")
    `RDE_ASSERT_NOW(a_no_write_in_drain, i_clk, i_rst_n, r_state == ST_DRAIN, !mem_we,
        "element memory written during a drain")
    `RDE_ASSERT_NOW(a_status_is_last, i_clk, i_rst_n,
        r_out_valid && (r_out_kind != rde_pkg::K_ELEM), r_out_last,
        "status result not flagged last")
    `RDE_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n,
        in_acc && (i_opcode == rde_pkg::OP_FIN),
        (r_count == '0) && !r_rev && !r_err && !r_ovf && (r_head == '0),
        "deque state not cleared by finish")

endmodule
